// ----- src/khts_pkg.sv -----
// Package for the keyed hash table store: shared constants, result and
// operation codes, and the command and status structs between controller
// and datapath. No dependencies.
`default_nettype none

package khts_pkg;

    localparam int OP_W      = 2;
    localparam int KEY_W     = 31;
    localparam int VALUE_W   = 64;
    localparam int STATUS_W  = 3;

    localparam int KEY_PAD_W  = 32;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam op_t OP_INSERT = 2'd0;
    localparam op_t OP_REMOVE = 2'd1;
    localparam op_t OP_SEARCH = 2'd2;

    localparam status_t ST_INSERTED  = 3'd0;
    localparam status_t ST_REPLACED  = 3'd1;
    localparam status_t ST_REMOVED   = 3'd2;
    localparam status_t ST_NOT_FOUND = 3'd3;
    localparam status_t ST_FOUND     = 3'd4;
    localparam status_t ST_FULL      = 3'd5;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic mod_step;
        logic rd;
        logic commit;
    } khts_cmd_t;

    typedef struct packed {
        logic clr_last;
    } khts_sts_t;

endpackage

`default_nettype wire

// ----- src/khts_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module khts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/khts_ctrl.sv -----
// Controller state machine of the keyed hash table store.
// Depends on khts_pkg for the command and status structs.
`default_nettype none

module khts_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire khts_pkg::khts_sts_t sts,
    output logic                    busy,
    output khts_pkg::khts_cmd_t     cmd
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_MOD   = 5'b00100,
        S_READ  = 5'b01000,
        S_CMP   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                state_next   = S_READ;
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ----- src/khts_dp.sv -----
// Datapath of the keyed hash table store: request registers, bucket
// remainder unit, bucket row RAM, slot compare and result registers.
// Depends on khts_pkg and khts_ram.
`default_nettype none

module khts_dp #(
    parameter int BUCKETS          = 16,
    parameter int SLOTS_PER_BUCKET = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire khts_pkg::khts_cmd_t           cmd,
    output khts_pkg::khts_sts_t                sts,
    input  wire logic [khts_pkg::OP_W-1:0]     operation,
    input  wire logic [khts_pkg::KEY_W-1:0]    key,
    input  wire logic [khts_pkg::VALUE_W-1:0]  value,
    output logic                               done,
    output logic [khts_pkg::STATUS_W-1:0]      status,
    output logic [khts_pkg::VALUE_W-1:0]       found_value,
    output logic                               table_empty
);

    localparam int SLOTS  = SLOTS_PER_BUCKET;
    localparam int AW     = $clog2(BUCKETS);
    localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW     = $clog2(BUCKETS * SLOTS + 1);
    localparam int KOFF   = SLOTS;
    localparam int VOFF   = SLOTS * (1 + khts_pkg::KEY_W);
    localparam int RW     = SLOTS * (1 + khts_pkg::KEY_W + khts_pkg::VALUE_W);
    localparam int PW     = khts_pkg::KEY_W + khts_pkg::KEY_PAD_W;
    localparam logic [khts_pkg::KEY_PAD_W-1:0] BUCKET_C = khts_pkg::KEY_PAD_W'(BUCKETS);
    localparam logic [khts_pkg::KEY_PAD_W-1:0] RECIP =
        khts_pkg::KEY_PAD_W'((64'd1 << khts_pkg::KEY_PAD_W) / 64'(BUCKETS));
    localparam logic [AW-1:0] LAST_ROW = AW'(BUCKETS - 1);

    logic [khts_pkg::OP_W-1:0]      op_reg;
    logic [khts_pkg::KEY_W-1:0]     key_reg;
    logic [khts_pkg::VALUE_W-1:0]   val_reg;
    logic [khts_pkg::KEY_W-1:0]     quot_reg;
    logic [PW-1:0]                  quot_prod;
    logic [khts_pkg::KEY_PAD_W-1:0] rem_wide;
    logic [AW-1:0]                  rem_reg;
    logic [AW-1:0]                  rem_next;
    logic [AW-1:0]                  clr_ptr_reg;
    logic [CW-1:0]                  count_reg;
    logic [CW-1:0]                  count_next;
    logic                           done_reg;
    logic [khts_pkg::STATUS_W-1:0]  status_reg;
    logic [khts_pkg::STATUS_W-1:0]  status_next;
    logic [khts_pkg::VALUE_W-1:0]   found_reg;
    logic [khts_pkg::VALUE_W-1:0]   found_next;
    logic                           empty_reg;

    logic [RW-1:0]                  rdata;
    logic [RW-1:0]                  wrow;
    logic [RW-1:0]                  ram_wdata;
    logic [AW-1:0]                  ram_waddr;
    logic                           ram_we;
    logic                           row_we;

    logic [SLOTS-1:0]               rv;
    logic [khts_pkg::KEY_W-1:0]     rk   [SLOTS];
    logic [khts_pkg::VALUE_W-1:0]   rval [SLOTS];
    logic [SLOTS-1:0]               wv;
    logic [khts_pkg::KEY_W-1:0]     wk   [SLOTS];
    logic [khts_pkg::VALUE_W-1:0]   wval [SLOTS];
    logic [SLOTS-1:0]               match;
    logic                           hit;
    logic                           has_free;
    logic [SW-1:0]                  hit_idx;
    logic [SW-1:0]                  free_idx;

    // The reciprocal quotient is at most one below the true one, so a single
    // compare and subtract brings the remainder into range.
    assign quot_prod = PW'(key) * PW'(RECIP);
    assign rem_wide  = khts_pkg::KEY_PAD_W'(key_reg)
                     - khts_pkg::KEY_PAD_W'(quot_reg) * BUCKET_C;
    assign rem_next  = (rem_wide >= BUCKET_C) ? AW'(rem_wide - BUCKET_C) : AW'(rem_wide);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            key_reg  <= key;
            val_reg  <= value;
            quot_reg <= quot_prod[PW-1:khts_pkg::KEY_PAD_W];
        end
        if (cmd.commit)
        begin
            status_reg <= status_next;
            found_reg  <= found_next;
            empty_reg  <= (count_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg     <= '0;
            clr_ptr_reg <= '0;
            count_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.commit;
            if (cmd.mod_step)
            begin
                rem_reg <= rem_next;
            end
            if (cmd.clr_step)
            begin
                clr_ptr_reg <= clr_ptr_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                count_reg <= count_next;
            end
        end
    end

    assign sts.clr_last = (clr_ptr_reg == LAST_ROW);

    always_comb
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            rv[s]    = rdata[s];
            rk[s]    = rdata[KOFF + s * khts_pkg::KEY_W +: khts_pkg::KEY_W];
            rval[s]  = rdata[VOFF + s * khts_pkg::VALUE_W +: khts_pkg::VALUE_W];
            match[s] = rv[s] && (rk[s] == key_reg);
        end
    end

    always_comb
    begin
        hit      = 1'b0;
        has_free = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (match[s])
            begin
                hit     = 1'b1;
                hit_idx = SW'(s);
            end
            if (!rv[s])
            begin
                has_free = 1'b1;
                free_idx = SW'(s);
            end
        end
    end

    always_comb
    begin
        wv          = rv;
        wk          = rk;
        wval        = rval;
        row_we      = 1'b0;
        count_next  = count_reg;
        found_next  = '0;
        status_next = khts_pkg::ST_NOT_FOUND;
        case (op_reg)
            khts_pkg::OP_INSERT:
            begin
                if (hit)
                begin
                    wval[hit_idx] = val_reg;
                    row_we        = 1'b1;
                    status_next   = khts_pkg::ST_REPLACED;
                end
                else if (has_free)
                begin
                    wv[free_idx]   = 1'b1;
                    wk[free_idx]   = key_reg;
                    wval[free_idx] = val_reg;
                    row_we         = 1'b1;
                    count_next     = count_reg + 1'b1;
                    status_next    = khts_pkg::ST_INSERTED;
                end
                else
                begin
                    status_next = khts_pkg::ST_FULL;
                end
            end
            khts_pkg::OP_REMOVE:
            begin
                if (hit)
                begin
                    wv[hit_idx] = 1'b0;
                    row_we      = 1'b1;
                    count_next  = count_reg - 1'b1;
                    status_next = khts_pkg::ST_REMOVED;
                end
            end
            default:
            begin
                if (hit)
                begin
                    found_next  = rval[hit_idx];
                    status_next = khts_pkg::ST_FOUND;
                end
            end
        endcase
    end

    always_comb
    begin
        wrow = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            wrow[s] = wv[s];
            wrow[KOFF + s * khts_pkg::KEY_W +: khts_pkg::KEY_W]       = wk[s];
            wrow[VOFF + s * khts_pkg::VALUE_W +: khts_pkg::VALUE_W]   = wval[s];
        end
    end

    assign ram_we    = cmd.clr_step || (cmd.commit && row_we);
    assign ram_waddr = cmd.clr_step ? clr_ptr_reg : rem_reg;
    assign ram_wdata = cmd.clr_step ? '0 : wrow;

    khts_ram #(
        .WIDTH (RW),
        .DEPTH (BUCKETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd),
        .raddr (rem_reg),
        .rdata (rdata)
    );

    assign done        = done_reg;
    assign status      = status_reg;
    assign found_value = found_reg;
    assign table_empty = empty_reg;

endmodule

`default_nettype wire

// ----- src/keyed_hash_table_store.sv -----
// Top level of the keyed hash table store: controller plus datapath.
// Depends on khts_pkg, khts_ctrl and khts_dp (which holds khts_ram).
//
//   Channel   Handshake            Beat
//   request   start & !busy        operation, key, value
//   result    done (one cycle)     status, found_value, table_empty
//
// Busy stays high from the accept edge until the bucket row is written back.
// At the accept edge a quotient estimate of the key by the bucket count is
// taken with a constant reciprocal; in S_MOD it is turned into the bucket
// index, in S_READ the bucket row is read and in S_CMP it is compared and
// written. The done strobe comes in the cycle after the write, when busy is
// already low. After reset a clearing pass writes every bucket row with busy
// high. The receiver cannot stall; each result beat lasts one cycle.
`default_nettype none

module keyed_hash_table_store #(
    parameter int BUCKETS          = 16,
    parameter int SLOTS_PER_BUCKET = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [khts_pkg::OP_W-1:0]     operation,
    input  wire logic [khts_pkg::KEY_W-1:0]    key,
    input  wire logic [khts_pkg::VALUE_W-1:0]  value,
    output logic                               done,
    output logic [khts_pkg::STATUS_W-1:0]      status,
    output logic [khts_pkg::VALUE_W-1:0]       found_value,
    output logic                               table_empty
);

    khts_pkg::khts_cmd_t cmd;
    khts_pkg::khts_sts_t sts;

    khts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    khts_dp #(
        .BUCKETS          (BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .operation   (operation),
        .key         (key),
        .value       (value),
        .done        (done),
        .status      (status),
        .found_value (found_value),
        .table_empty (table_empty)
    );

endmodule

`default_nettype wire

// ----- sim/keyed_hash_table_store_test.sv -----
// Testbench for keyed_hash_table_store: a directed table followed by random insert, remove
// and search traffic, each result checked against a predictor of the bucketed table
// or a typed answer. Depends on khts_pkg and the keyed_hash_table_store RTL.
`timescale 1ns / 100ps

module keyed_hash_table_store_test;

    import khts_pkg::*;

    localparam int BUCKETS      = 16;
    localparam int SLOTS        = 8;
    localparam int TOTAL_SLOTS  = BUCKETS * SLOTS;
    localparam int RANDOM_ITEMS = 1950;
    localparam int EPOCH_LEN    = 150;
    localparam int POOL_SIZE    = 12;

    localparam op_t OP_SPARE = 2'd3;

    localparam logic [VALUE_W-1:0] ONES = {VALUE_W{1'b1}};
    localparam logic [KEY_W-1:0]   KEY_MAX = {KEY_W{1'b1}};

    typedef struct packed {
        status_t              status;
        logic [VALUE_W-1:0]   found_value;
        logic                 table_empty;
    } answer_t;

    typedef struct packed {
        op_t                  op;
        logic [KEY_W-1:0]     key;
        logic [VALUE_W-1:0]   value;
        logic                 typed;
        status_t              status;
        logic [VALUE_W-1:0]   found_value;
        logic                 table_empty;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 24;

    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{OP_SEARCH, 31'd0,  64'd0, 1'b1, ST_NOT_FOUND, 64'd0, 1'b1},
        '{OP_REMOVE, 31'd5,  64'd0, 1'b1, ST_NOT_FOUND, 64'd0, 1'b1},
        '{OP_SPARE,  31'd7,  ONES,  1'b1, ST_NOT_FOUND, 64'd0, 1'b1},
        '{OP_INSERT, 31'd0,  ONES,  1'b1, ST_INSERTED,  64'd0, 1'b0},
        '{OP_SEARCH, 31'd0,  64'd0, 1'b1, ST_FOUND,     ONES,  1'b0},
        '{OP_INSERT, KEY_MAX, 64'd0, 1'b1, ST_INSERTED, 64'd0, 1'b0},
        '{OP_SPARE,  KEY_MAX, ONES, 1'b1, ST_FOUND,     64'd0, 1'b0},
        '{OP_INSERT, 31'd0,  64'h0123_4567_89AB_CDEF, 1'b1, ST_REPLACED, 64'd0, 1'b0},
        '{OP_INSERT, 31'd1,   64'hA5A5_0000_0000_0001, 1'b0, ST_INSERTED, 64'd0, 1'b0},
        '{OP_INSERT, 31'd17,  64'hA5A5_0000_0000_0011, 1'b0, ST_INSERTED, 64'd0, 1'b0},
        '{OP_INSERT, 31'd33,  64'hA5A5_0000_0000_0021, 1'b0, ST_INSERTED, 64'd0, 1'b0},
        '{OP_INSERT, 31'd49,  64'hA5A5_0000_0000_0031, 1'b0, ST_INSERTED, 64'd0, 1'b0},
        '{OP_INSERT, 31'd65,  64'hA5A5_0000_0000_0041, 1'b0, ST_INSERTED, 64'd0, 1'b0},
        '{OP_INSERT, 31'd81,  64'hA5A5_0000_0000_0051, 1'b0, ST_INSERTED, 64'd0, 1'b0},
        '{OP_INSERT, 31'd97,  64'hA5A5_0000_0000_0061, 1'b0, ST_INSERTED, 64'd0, 1'b0},
        '{OP_INSERT, 31'd113, 64'hA5A5_0000_0000_0071, 1'b0, ST_INSERTED, 64'd0, 1'b0},
        '{OP_INSERT, 31'd129, 64'hDEAD_BEEF_0000_0081, 1'b1, ST_FULL,     64'd0, 1'b0},
        '{OP_INSERT, 31'd17,  64'h5A5A_FFFF_0000_0011, 1'b0, ST_REPLACED, 64'd0, 1'b0},
        '{OP_REMOVE, 31'd49,  64'd0, 1'b1, ST_REMOVED,   64'd0, 1'b0},
        '{OP_INSERT, 31'd145, 64'hC3C3_0000_0000_0091, 1'b0, ST_INSERTED, 64'd0, 1'b0},
        '{OP_SEARCH, 31'd145, 64'd0, 1'b0, ST_FOUND,     64'd0, 1'b0},
        '{OP_REMOVE, 31'd49,  64'd0, 1'b1, ST_NOT_FOUND, 64'd0, 1'b0},
        '{OP_INSERT, 31'd49,  ONES,  1'b1, ST_FULL,      64'd0, 1'b0},
        '{OP_SEARCH, 31'h5555_5555, ONES, 1'b1, ST_NOT_FOUND, 64'd0, 1'b0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    op_t                   operation;
    logic [KEY_W-1:0]      key;
    logic [VALUE_W-1:0]    value;
    wire                   busy;
    wire                   done;
    wire  [STATUS_W-1:0]   status;
    wire  [VALUE_W-1:0]    found_value;
    wire                   table_empty;

    logic                  slot_used [TOTAL_SLOTS];
    logic [KEY_W-1:0]      slot_key_copy [TOTAL_SLOTS];
    logic [VALUE_W-1:0]    slot_value_copy [TOTAL_SLOTS];
    int                    stored_count;

    answer_t               answers_due [$];
    int                    mismatches = 0;
    int                    results_seen = 0;
    int                    requests_sent = 0;
    int                    times_emptied = 0;
    int                    status_seen [8];
    logic                  was_empty = 1'b1;

    keyed_hash_table_store #(
        .BUCKETS          (BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .key         (key),
        .value       (value),
        .done        (done),
        .status      (status),
        .found_value (found_value),
        .table_empty (table_empty)
    );

    always #6 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic answer_t table_answer(op_t op, logic [KEY_W-1:0] k,
                                             logic [VALUE_W-1:0] v);
        answer_t a;
        int base;
        int hit;
        int free;
        a = '0;
        base = int'(k % BUCKETS) * SLOTS;
        hit = -1;
        free = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_used[base + i] && slot_key_copy[base + i] == k && hit < 0)
                hit = base + i;
            if (!slot_used[base + i] && free < 0)
                free = base + i;
        end
        case (op)
            OP_INSERT:
            begin
                if (hit >= 0)
                begin
                    slot_value_copy[hit] = v;
                    a.status = ST_REPLACED;
                end
                else if (free >= 0)
                begin
                    slot_used[free] = 1'b1;
                    slot_key_copy[free] = k;
                    slot_value_copy[free] = v;
                    stored_count++;
                    a.status = ST_INSERTED;
                end
                else
                    a.status = ST_FULL;
            end
            OP_REMOVE:
            begin
                if (hit >= 0)
                begin
                    slot_used[hit] = 1'b0;
                    stored_count--;
                    a.status = ST_REMOVED;
                end
                else
                    a.status = ST_NOT_FOUND;
            end
            default:
            begin
                if (hit >= 0)
                begin
                    a.found_value = slot_value_copy[hit];
                    a.status = ST_FOUND;
                end
                else
                    a.status = ST_NOT_FOUND;
            end
        endcase
        a.table_empty = (stored_count == 0);
        return a;
    endfunction

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && done)
        begin
            results_seen++;
            status_seen[status]++;
            if (table_empty && !was_empty)
                times_emptied++;
            was_empty = table_empty;
            if (answers_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: status %0d value %h empty %0b",
                             status, found_value, table_empty);
            end
            else
            begin
                want = answers_due.pop_front();
                if (status !== want.status || found_value !== want.found_value ||
                    table_empty !== want.table_empty)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected status %0d value %h empty %0b, got %0d %h %0b",
                                 results_seen, want.status, want.found_value, want.table_empty,
                                 status, found_value, table_empty);
                end
            end
        end
    end

    task automatic send_request(op_t op, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v,
                                logic typed, answer_t typed_answer);
        answer_t predicted;
        operation <= op;
        key <= k;
        value <= v;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = table_answer(op, k, v);
        answers_due.push_back(typed ? typed_answer : predicted);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic hold_off(int cycles);
        start <= 1'b0;
        operation <= op_t'($urandom);
        key <= KEY_W'($urandom);
        value <= {$urandom, $urandom};
        repeat (cycles)
            @(negedge clk);
    endtask

    task automatic wait_for_results();
        if (answers_due.size() != 0)
        begin
            start <= 1'b0;
            while (answers_due.size() != 0)
                @(negedge clk);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 20);
        return $urandom_range(30, 80);
    endfunction

    initial
    begin
        logic [KEY_W-5:0]     key_high [POOL_SIZE];
        answer_t              typed_answer;
        stim_row_t            row;
        op_t                  op;
        logic [KEY_W-1:0]     k;
        logic [VALUE_W-1:0]   v;
        int                   epoch;
        int                   span;
        int                   bucket_lo;
        int                   r;
        int                   gap;
        int                   settle;
        logic                 quiet;

        rst_n = 1'b0;
        start = 1'b0;
        operation = OP_INSERT;
        key = '0;
        value = '0;
        stored_count = 0;
        epoch = 0;
        span = BUCKETS;
        bucket_lo = 0;
        quiet = 1'b0;
        foreach (slot_used[i])
            slot_used[i] = 1'b0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        foreach (key_high[i])
            key_high[i] = (KEY_W-4)'($urandom);

        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int n = 0; n < DIRECTED_ROWS; n++)
        begin
            row = DIRECTED[n];
            typed_answer.status = row.status;
            typed_answer.found_value = row.found_value;
            typed_answer.table_empty = row.table_empty;
            send_request(row.op, row.key, row.value, row.typed, typed_answer);
            gap = pick_gap();
            if (gap > 0)
                hold_off(gap);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % EPOCH_LEN == 0)
            begin
                epoch = n / EPOCH_LEN;
                span = $urandom_range(0, 1) ? 2 : BUCKETS;
                bucket_lo = $urandom_range(0, BUCKETS - span);
                quiet = ($urandom_range(0, 3) == 0);
                if (epoch == 1 || $urandom_range(0, 1))
                    wait_for_results();
            end
            r = $urandom_range(0, 99);
            if (epoch % 2 == 0)
                op = r < 60 ? OP_INSERT : r < 80 ? OP_REMOVE : r < 95 ? OP_SEARCH : OP_SPARE;
            else
                op = r < 15 ? OP_INSERT : r < 75 ? OP_REMOVE : r < 95 ? OP_SEARCH : OP_SPARE;
            if ($urandom_range(0, 99) < 8)
                k = KEY_W'($urandom);
            else
                k = {key_high[$urandom_range(0, POOL_SIZE - 1)],
                     4'(bucket_lo + $urandom_range(0, span - 1))};
            r = $urandom_range(0, 99);
            v = r < 5 ? '0 : r < 10 ? ONES : {$urandom, $urandom};
            send_request(op, k, v, 1'b0, '0);
            if (!quiet)
            begin
                gap = pick_gap();
                if (gap > 0)
                    hold_off(gap);
            end
        end

        start <= 1'b0;
        settle = 0;
        while (answers_due.size() != 0 && settle < 2000)
        begin
            @(negedge clk);
            settle++;
        end
        repeat (20)
            @(negedge clk);
        if (answers_due.size() != 0)
        begin
            mismatches += answers_due.size();
            $display("%0d expected results never arrived", answers_due.size());
        end

        $display("Sent %0d requests: %0d inserted, %0d replaced, %0d removed, %0d not found,",
                 requests_sent, status_seen[ST_INSERTED], status_seen[ST_REPLACED],
                 status_seen[ST_REMOVED], status_seen[ST_NOT_FOUND]);
        $display("%0d found, %0d bucket full; the table drained to empty %0d times.",
                 status_seen[ST_FOUND], status_seen[ST_FULL], times_emptied);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
